// ----- rtl/amta_pkg.sv -----
// Package for the multi-device memory task allocator.
// Holds the transfer payload types, command and register codes, the sequencer
// state type and the shared unit's operation codes. It depends on nothing.
`default_nettype none

package amta_pkg;

    // Command codes carried in the action field.
    localparam logic [1:0] ACT_TICK   = 2'd0;
    localparam logic [1:0] ACT_SUBMIT = 2'd1;
    localparam logic [1:0] ACT_CANCEL = 2'd2;

    // Configuration register indexes and port widths.
    localparam int CFG_INDEX_W = 8;
    localparam int CFG_DATA_W  = 16;
    localparam logic [CFG_INDEX_W-1:0] CFG_NUM_DEVICES   = 8'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_DEVICE_MEMORY = 8'd1;

    // Register values after reset.
    localparam logic [4:0]  RST_NUM_DEVICES   = 5'd16;
    localparam logic [15:0] RST_DEVICE_MEMORY = 16'd16384;

    typedef struct packed {
        logic [1:0]  action;
        logic [15:0] task_key;
        logic [4:0]  need_devices;
        logic [15:0] need_memory;
        logic [15:0] duration;
    } in_t;

    typedef struct packed {
        logic accepted;
        logic table_full;
    } out_t;

    typedef enum logic [1:0] {
        ALU_GE,
        ALU_SUB,
        ALU_ADD_SAT
    } alu_op_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SUB_RD,
        ST_SUB_CHK,
        ST_DED_RD,
        ST_DED_WR,
        ST_APPEND,
        ST_TSK_RD,
        ST_TSK_CHK,
        ST_REL_RD,
        ST_REL_WR,
        ST_DONE
    } state_t;

endpackage

`default_nettype wire

// ----- rtl/amta_alu.sv -----
// Shared 16-bit arithmetic unit: compare, subtract and saturating add.
// Used by the device scan, deduction and release passes of the allocator sequencer. Depends on amta_pkg.
`default_nettype none

module amta_alu (
    input  amta_pkg::alu_op_t op,
    input  logic [15:0]       a,
    input  logic [15:0]       b,
    output logic [15:0]       res,
    output logic              ge
);
    import amta_pkg::*;

    logic [16:0] sum;
    logic [16:0] diff;

    assign sum  = {1'b0, a} + {1'b0, b};
    assign diff = {1'b0, a} - {1'b0, b};
    // No borrow means a is at least b.
    assign ge   = ~diff[16];

    always_comb begin
        unique case (op)
            ALU_SUB:     res = diff[15:0];
            ALU_ADD_SAT: res = sum[16] ? 16'hFFFF : sum[15:0];
            default:     res = diff[15:0];
        endcase
    end

endmodule

`default_nettype wire

// ----- rtl/amta_free_mem.sv -----
// Free memory store: one 16-bit word per device with a registered read port.
// An entry not written since reset or the last clear reads as the init value.
`default_nettype none

module amta_free_mem #(
    parameter int DEVICES = 16,
    parameter int AW      = 4
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          clear,
    input  logic [15:0]   init_value,
    input  logic          rd_en,
    input  logic          wr_en,
    input  logic [AW-1:0] addr,
    input  logic [15:0]   wr_data,
    output logic [15:0]   rd_data
);
    logic [15:0]        mem [DEVICES];
    logic [DEVICES-1:0] valid_reg;
    logic [15:0]        rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn || clear) begin
            valid_reg <= '0;
        end else if (wr_en) begin
            valid_reg[addr] <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= valid_reg[addr] ? mem[addr] : init_value;
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

// ----- rtl/amta_task_ram.sv -----
// Task table memory: one write port and one registered read port.
// Entries are packed by the top level; contents are undefined until written.
`default_nettype none

module amta_task_ram #(
    parameter int WIDTH = 129,
    parameter int DEPTH = 64,
    parameter int AW    = 6
) (
    input  logic             aclk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             rd_en,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);
    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

// ----- rtl/multi_device_memory_task_allocator.sv -----
// Top level of the multi-device memory task allocator: sequencer, registers
// and result stage. Depends on amta_pkg, amta_alu, amta_free_mem, amta_task_ram.
//
// Use: commands arrive on the s_ channel (valid/ready); each command yields
// exactly one result transfer on the m_ channel. A tick advances time and
// releases tasks that end now, a submit claims memory on the first devices
// with room, a cancel releases a running task by key. The cfg_ channel writes
// the device count (index 0) or the per-device capacity (index 1); a write to either
// restarts the allocator: all devices free, time zero, task table empty.
// Writes are taken at any time but are meant to be issued while idle.
// One command occupies the sequencer, and s_ready stays low, until
// its result is loaded into the output register. A submit scans the devices
// in use until enough have room; if they do, it deducts from each chosen device
// and appends the task. A tick or cancel reads the table entry by entry,
// and each release visits every device in use, as every free-memory word goes through
// the single shared ALU and the single-port free-memory store.
// The output register holds a result while the receiver stalls; the next
// command is taken meanwhile, and its result waits until that one leaves.
// Reset is synchronous and restores the register defaults (16 devices,
// 16384 words each) with no clearing pass.
`default_nettype none

module multi_device_memory_task_allocator #(
    parameter int DEVICES = 16,
    parameter int TASKS   = 64
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 s_valid,
    output logic                                 s_ready,
    input  amta_pkg::in_t                        s_data,
    output logic                                 m_valid,
    input  logic                                 m_ready,
    output amta_pkg::out_t                       m_data,
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [amta_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  logic [amta_pkg::CFG_DATA_W-1:0]      cfg_data
);
    import amta_pkg::*;

    localparam int DEV_AW  = (DEVICES > 1) ? $clog2(DEVICES) : 1;
    localparam int DEV_CW  = $clog2(DEVICES + 1);
    localparam int TASK_AW = (TASKS > 1) ? $clog2(TASKS) : 1;
    localparam int TASK_CW = $clog2(TASKS + 1);
    // Entry layout: running, device mask, end time, amount, key.
    localparam int KEY_LO  = 0;
    localparam int AMT_LO  = 16;
    localparam int END_LO  = 32;
    localparam int MASK_LO = 64;
    localparam int RUN_BIT = MASK_LO + DEVICES;
    localparam int ENTRY_W = RUN_BIT + 1;

    state_t               state_reg, state_next;
    in_t                  item_reg, item_next;
    logic [4:0]           num_devices_reg, num_devices_next;
    logic [15:0]          device_memory_reg, device_memory_next;
    logic [31:0]          now_reg, now_next;
    logic [TASK_CW-1:0]   task_count_reg, task_count_next;
    logic [DEV_CW-1:0]    dev_idx_reg, dev_idx_next;
    logic [DEV_CW-1:0]    cnt_reg, cnt_next;
    logic [DEVICES-1:0]   mask_reg, mask_next;
    logic [TASK_CW-1:0]   ent_idx_reg, ent_idx_next;
    logic                 acc_reg, acc_next;
    logic                 full_reg, full_next;
    logic                 m_valid_reg, m_valid_next;
    out_t                 m_data_reg, m_data_next;

    // Free-memory store and shared unit connections.
    logic                 fm_rd_en, fm_wr_en;
    logic [15:0]          fm_rd_data;
    alu_op_t              alu_op;
    logic [15:0]          alu_b, alu_res;
    logic                 alu_ge;
    // Only a write to one of the two registers restarts the allocator.
    logic                 cfg_restart;

    // Task table connections.
    logic                 tr_wr_en, tr_rd_en;
    logic [TASK_AW-1:0]   tr_wr_addr;
    logic [ENTRY_W-1:0]   tr_wr_data, tr_rd_data;

    logic [DEV_CW-1:0]    used_n;
    logic [DEV_CW-1:0]    dev_idx_inc;
    logic [DEV_CW-1:0]    cnt_inc;
    logic [TASK_CW-1:0]   ent_idx_inc;
    logic                 dev_last;
    logic                 ent_last;
    logic                 cur_bit;
    logic                 ent_running;

    assign cfg_restart = cfg_valid && cfg_ready &&
                         ((cfg_index == CFG_NUM_DEVICES) || (cfg_index == CFG_DEVICE_MEMORY));

    amta_alu u_alu (
        .op  (alu_op),
        .a   (fm_rd_data),
        .b   (alu_b),
        .res (alu_res),
        .ge  (alu_ge)
    );

    amta_free_mem #(
        .DEVICES (DEVICES),
        .AW      (DEV_AW)
    ) u_free_mem (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .clear      (cfg_restart),
        .init_value (device_memory_reg),
        .rd_en      (fm_rd_en),
        .wr_en      (fm_wr_en),
        .addr       (dev_idx_reg[DEV_AW-1:0]),
        .wr_data    (alu_res),
        .rd_data    (fm_rd_data)
    );

    amta_task_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (TASKS),
        .AW    (TASK_AW)
    ) u_task_ram (
        .aclk    (aclk),
        .wr_en   (tr_wr_en),
        .wr_addr (tr_wr_addr),
        .wr_data (tr_wr_data),
        .rd_en   (tr_rd_en),
        .rd_addr (ent_idx_reg[TASK_AW-1:0]),
        .rd_data (tr_rd_data)
    );

    // Devices in use: the configured count, limited to the devices built.
    always_comb begin
        if (32'(num_devices_reg) < DEVICES) begin
            used_n = DEV_CW'(num_devices_reg);
        end else begin
            used_n = DEV_CW'(DEVICES);
        end
    end

    assign dev_idx_inc = dev_idx_reg + DEV_CW'(1);
    assign dev_last    = (dev_idx_inc == used_n);
    assign cnt_inc     = cnt_reg + DEV_CW'(alu_ge);
    assign ent_idx_inc = ent_idx_reg + TASK_CW'(1);
    assign ent_last    = (ent_idx_inc == task_count_reg);
    assign cur_bit     = mask_reg[dev_idx_reg[DEV_AW-1:0]];
    assign ent_running = tr_rd_data[RUN_BIT];

    assign s_ready   = (state_reg == ST_IDLE);
    assign cfg_ready = 1'b1;
    assign m_valid   = m_valid_reg;
    assign m_data    = m_data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg         <= ST_IDLE;
            num_devices_reg   <= RST_NUM_DEVICES;
            device_memory_reg <= RST_DEVICE_MEMORY;
            now_reg           <= '0;
            task_count_reg    <= '0;
            m_valid_reg       <= 1'b0;
        end else begin
            state_reg         <= state_next;
            num_devices_reg   <= num_devices_next;
            device_memory_reg <= device_memory_next;
            now_reg           <= now_next;
            task_count_reg    <= task_count_next;
            m_valid_reg       <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        item_reg    <= item_next;
        dev_idx_reg <= dev_idx_next;
        cnt_reg     <= cnt_next;
        mask_reg    <= mask_next;
        ent_idx_reg <= ent_idx_next;
        acc_reg     <= acc_next;
        full_reg    <= full_next;
        m_data_reg  <= m_data_next;
    end

    always_comb begin
        state_next         = state_reg;
        item_next          = item_reg;
        num_devices_next   = num_devices_reg;
        device_memory_next = device_memory_reg;
        now_next           = now_reg;
        task_count_next    = task_count_reg;
        dev_idx_next       = dev_idx_reg;
        cnt_next           = cnt_reg;
        mask_next          = mask_reg;
        ent_idx_next       = ent_idx_reg;
        acc_next           = acc_reg;
        full_next          = full_reg;
        m_valid_next       = m_valid_reg && !m_ready;
        m_data_next        = m_data_reg;

        fm_rd_en   = 1'b0;
        fm_wr_en   = 1'b0;
        alu_op     = ALU_GE;
        alu_b      = item_reg.need_memory;
        tr_rd_en   = 1'b0;
        tr_wr_en   = 1'b0;
        tr_wr_addr = ent_idx_reg[TASK_AW-1:0];
        // Default write stores the entry just read with its running flag cleared.
        tr_wr_data = {1'b0, tr_rd_data[RUN_BIT-1:0]};

        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    item_next    = s_data;
                    acc_next     = 1'b0;
                    full_next    = 1'b0;
                    dev_idx_next = '0;
                    cnt_next     = '0;
                    mask_next    = '0;
                    ent_idx_next = '0;
                    unique case (s_data.action)
                        ACT_TICK: begin
                            now_next   = now_reg + 32'd1;
                            state_next = (task_count_reg == '0) ? ST_DONE : ST_TSK_RD;
                        end
                        ACT_SUBMIT: begin
                            if (32'(task_count_reg) == TASKS) begin
                                full_next  = 1'b1;
                                state_next = ST_DONE;
                            end else if (used_n == '0) begin
                                state_next = ST_DONE;
                            end else begin
                                state_next = ST_SUB_RD;
                            end
                        end
                        ACT_CANCEL: begin
                            state_next = (task_count_reg == '0) ? ST_DONE : ST_TSK_RD;
                        end
                        default: begin
                            state_next = ST_DONE;
                        end
                    endcase
                end
            end

            ST_SUB_RD: begin
                fm_rd_en   = 1'b1;
                state_next = ST_SUB_CHK;
            end

            ST_SUB_CHK: begin
                // The count is checked after each device test, as a zero
                // request is met only when device 0 does not qualify.
                cnt_next  = cnt_inc;
                mask_next = mask_reg | (DEVICES'(alu_ge) << dev_idx_reg[DEV_AW-1:0]);
                if (32'(cnt_inc) == 32'(item_reg.need_devices)) begin
                    acc_next     = 1'b1;
                    dev_idx_next = '0;
                    state_next   = ST_DED_RD;
                end else if (dev_last) begin
                    state_next = ST_DONE;
                end else begin
                    dev_idx_next = dev_idx_inc;
                    state_next   = ST_SUB_RD;
                end
            end

            ST_DED_RD: begin
                fm_rd_en   = 1'b1;
                state_next = ST_DED_WR;
            end

            ST_DED_WR: begin
                alu_op   = ALU_SUB;
                fm_wr_en = cur_bit;
                if (dev_last) begin
                    state_next = ST_APPEND;
                end else begin
                    dev_idx_next = dev_idx_inc;
                    state_next   = ST_DED_RD;
                end
            end

            ST_APPEND: begin
                tr_wr_en        = 1'b1;
                tr_wr_addr      = task_count_reg[TASK_AW-1:0];
                tr_wr_data      = {1'b1, mask_reg, now_reg + 32'(item_reg.duration),
                                   item_reg.need_memory, item_reg.task_key};
                task_count_next = task_count_reg + TASK_CW'(1);
                state_next      = ST_DONE;
            end

            ST_TSK_RD: begin
                tr_rd_en   = 1'b1;
                state_next = ST_TSK_CHK;
            end

            ST_TSK_CHK: begin
                if (item_reg.action == ACT_TICK) begin
                    if (ent_running && (tr_rd_data[END_LO +: 32] == now_reg)) begin
                        tr_wr_en     = 1'b1;
                        mask_next    = tr_rd_data[MASK_LO +: DEVICES];
                        dev_idx_next = '0;
                        state_next   = ST_REL_RD;
                    end else if (ent_last) begin
                        state_next = ST_DONE;
                    end else begin
                        ent_idx_next = ent_idx_inc;
                        state_next   = ST_TSK_RD;
                    end
                end else begin
                    // Cancel stops at the first entry with a matching key.
                    if (tr_rd_data[KEY_LO +: 16] == item_reg.task_key) begin
                        if (ent_running) begin
                            tr_wr_en     = 1'b1;
                            acc_next     = 1'b1;
                            mask_next    = tr_rd_data[MASK_LO +: DEVICES];
                            dev_idx_next = '0;
                            state_next   = ST_REL_RD;
                        end else begin
                            state_next = ST_DONE;
                        end
                    end else if (ent_last) begin
                        state_next = ST_DONE;
                    end else begin
                        ent_idx_next = ent_idx_inc;
                        state_next   = ST_TSK_RD;
                    end
                end
            end

            ST_REL_RD: begin
                fm_rd_en   = 1'b1;
                state_next = ST_REL_WR;
            end

            ST_REL_WR: begin
                alu_op   = ALU_ADD_SAT;
                alu_b    = tr_rd_data[AMT_LO +: 16];
                fm_wr_en = cur_bit;
                if (!dev_last) begin
                    dev_idx_next = dev_idx_inc;
                    state_next   = ST_REL_RD;
                end else if ((item_reg.action == ACT_TICK) && !ent_last) begin
                    ent_idx_next = ent_idx_inc;
                    state_next   = ST_TSK_RD;
                end else begin
                    state_next = ST_DONE;
                end
            end

            ST_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next            = 1'b1;
                    m_data_next.accepted    = acc_reg;
                    m_data_next.table_full  = full_reg;
                    state_next              = ST_IDLE;
                end
            end

            default: begin
                state_next = ST_IDLE;
            end
        endcase

        // A register write restarts the allocator; the free-memory store is
        // cleared by the same transfer.
        if (cfg_valid) begin
            if (cfg_index == CFG_NUM_DEVICES) begin
                num_devices_next = cfg_data[4:0];
                now_next         = '0;
                task_count_next  = '0;
            end else if (cfg_index == CFG_DEVICE_MEMORY) begin
                device_memory_next = cfg_data;
                now_next           = '0;
                task_count_next    = '0;
            end
        end
    end

endmodule

`default_nettype wire

// ----- rtl/amta_checker.sv -----
// Port-level checker for the multi-device memory task allocator, with the
// bind that attaches it to the top level. Depends on amta_pkg.
`default_nettype none

module amta_checker (
    input logic           aclk,
    input logic           aresetn,
    input logic           s_valid,
    input logic           s_ready,
    input logic           m_valid,
    input logic           m_ready,
    input amta_pkg::out_t m_data
);
    import amta_pkg::*;

    // One command at a time: the block is busy right after a transfer in.
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready)
        else $error("s_ready high in the cycle after an input transfer");

    // A stalled result is held unchanged.
    a_result_held: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> (m_valid && $stable(m_data)))
        else $error("result changed or dropped while stalled");

    // A refusal for a full table is never a success.
    a_full_not_accepted: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> !(m_data.accepted && m_data.table_full))
        else $error("result both accepted and table full");

    // Reset empties the output stage.
    a_reset_clears: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("m_valid high after reset");

endmodule

bind multi_device_memory_task_allocator amta_checker u_amta_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_valid (s_valid),
    .s_ready (s_ready),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);

`default_nettype wire

// ----- tb/multi_device_memory_task_allocator_tb.sv -----
// Self-checking testbench for the multi-device memory task allocator: directed
// and random commands against a built-in allocation predictor.
// Depends on amta_pkg and the multi_device_memory_task_allocator top level.
`default_nettype none

module multi_device_memory_task_allocator_tb;
    import amta_pkg::*;

    localparam int DEVICES     = 16;
    localparam int TASKS       = 64;
    localparam int PHASES      = 10;
    localparam int PHASE_CMDS  = 115;
    localparam int HOLD_CYCLES = 300;
    localparam int STALL_LIMIT = 20000;
    localparam int DRAIN_WAIT  = 200;

    // Action code that the block does not define; it must do nothing.
    localparam logic [1:0] ACT_UNUSED = 2'd3;
    // Register index that maps to no register.
    localparam logic [CFG_INDEX_W-1:0] CFG_UNUSED = 8'hFF;

    typedef struct {
        in_t  cmd;
        logic typed;
        out_t want;
    } row_t;

    logic aclk = 1'b0;
    logic aresetn;
    logic s_valid;
    logic s_ready;
    in_t  s_data;
    logic m_valid;
    logic m_ready;
    out_t m_data;
    logic cfg_valid;
    logic cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;

    multi_device_memory_task_allocator #(
        .DEVICES(DEVICES),
        .TASKS  (TASKS)
    ) u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_valid  (s_valid),
        .s_ready  (s_ready),
        .s_data   (s_data),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_data   (m_data),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data (cfg_data)
    );

    always #5 aclk = ~aclk;

    // ------------------------------------------------------------------
    // Allocation predictor. It mirrors the allocator's registers, the free
    // memory of every device, the time counter and the task table.
    // ------------------------------------------------------------------
    logic [4:0]         cur_ndev;
    logic [15:0]        cur_cap;
    logic [15:0]        dev_free [DEVICES];
    logic [31:0]        sim_now;
    int unsigned        n_tasks;
    logic [15:0]        tk_key  [TASKS];
    logic               tk_busy [TASKS];
    logic [15:0]        tk_mem  [TASKS];
    logic [31:0]        tk_stop [TASKS];
    logic [DEVICES-1:0] tk_devs [TASKS];

    // Outcomes still owed by the block, oldest first.
    out_t        verdict_q [$];
    out_t        seen_want;
    int unsigned mismatch_count = 0;

    // Idling percentages for the two channels, and the request counter that
    // asks the receiver for one long hold-off.
    int unsigned send_gap_pct = 0;
    int unsigned recv_gap_pct = 0;
    int unsigned hold_asks    = 0;
    int unsigned hold_served  = 0;
    int unsigned hold_left    = 0;
    int unsigned quiet        = 0;

    // A write to either register restarts the allocator from empty.
    function automatic void restart_alloc();
        for (int j = 0; j < DEVICES; j++) dev_free[j] = cur_cap;
        for (int e = 0; e < TASKS; e++) tk_busy[e] = 1'b0;
        sim_now = '0;
        n_tasks = 0;
    endfunction

    function automatic void apply_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
        if (idx == CFG_NUM_DEVICES) begin
            cur_ndev = val[4:0];
            restart_alloc();
        end else if (idx == CFG_DEVICE_MEMORY) begin
            cur_cap = val;
            restart_alloc();
        end
    endfunction

    // Returning memory to a device saturates at the 16-bit ceiling.
    function automatic void release_task(int unsigned e);
        logic [16:0] sum;
        tk_busy[e] = 1'b0;
        for (int j = 0; j < DEVICES; j++) begin
            if (tk_devs[e][j]) begin
                sum = {1'b0, dev_free[j]} + {1'b0, tk_mem[e]};
                dev_free[j] = sum[16] ? 16'hFFFF : sum[15:0];
            end
        end
    endfunction

    function automatic out_t alloc_verdict(in_t cmd);
        out_t               res;
        int unsigned        lim;
        int unsigned        cnt;
        logic [DEVICES-1:0] mask;
        logic               hit;
        logic               found;
        res   = '0;
        cnt   = 0;
        mask  = '0;
        hit   = 1'b0;
        found = 1'b0;
        case (cmd.action)
            ACT_TICK: begin
                sim_now = sim_now + 32'd1;
                for (int unsigned e = 0; e < n_tasks; e++)
                    if (tk_busy[e] && tk_stop[e] == sim_now) release_task(e);
            end
            ACT_SUBMIT: begin
                if (n_tasks >= TASKS) begin
                    res.table_full = 1'b1;
                end else begin
                    lim = (cur_ndev < DEVICES) ? cur_ndev : DEVICES;
                    // The count is tested after each device, so asking for
                    // zero devices only succeeds when device 0 has no room.
                    for (int unsigned j = 0; j < lim && !hit; j++) begin
                        if (dev_free[j] >= cmd.need_memory) begin
                            mask[j] = 1'b1;
                            cnt++;
                        end
                        if (cnt == cmd.need_devices) hit = 1'b1;
                    end
                    if (hit) begin
                        for (int j = 0; j < DEVICES; j++)
                            if (mask[j]) dev_free[j] = dev_free[j] - cmd.need_memory;
                        tk_key[n_tasks]  = cmd.task_key;
                        tk_mem[n_tasks]  = cmd.need_memory;
                        tk_stop[n_tasks] = sim_now + {16'd0, cmd.duration};
                        tk_devs[n_tasks] = mask;
                        tk_busy[n_tasks] = 1'b1;
                        n_tasks++;
                        res.accepted = 1'b1;
                    end
                end
            end
            ACT_CANCEL: begin
                // Only the first entry with the key counts, running or not.
                for (int unsigned e = 0; e < n_tasks && !found; e++) begin
                    if (tk_key[e] == cmd.task_key) begin
                        found = 1'b1;
                        if (tk_busy[e]) begin
                            release_task(e);
                            res.accepted = 1'b1;
                        end
                    end
                end
            end
            default: ;
        endcase
        return res;
    endfunction

    // ------------------------------------------------------------------
    // Stimulus helpers.
    // ------------------------------------------------------------------
    function automatic row_t mk_row(logic [1:0] act, logic [15:0] key, logic [4:0] nd,
                                    logic [15:0] nm, logic [15:0] dur,
                                    logic typed, logic acc, logic full);
        row_t r;
        r.cmd.action       = act;
        r.cmd.task_key     = key;
        r.cmd.need_devices = nd;
        r.cmd.need_memory  = nm;
        r.cmd.duration     = dur;
        r.typed            = typed;
        r.want.accepted    = acc;
        r.want.table_full  = full;
        return r;
    endfunction

    // Random command shaped by the current setting: keys come mostly from a
    // small pool so that cancels find their tasks, durations are mostly short
    // so that ticks release them, and memory requests track the capacity.
    function automatic in_t gen_cmd(int unsigned submit_pct);
        in_t         c;
        int unsigned pick;
        int unsigned lim;
        pick = $urandom_range(99);
        if (pick < submit_pct)
            c.action = ACT_SUBMIT;
        else if (pick < submit_pct + (100 - submit_pct) * 6 / 10)
            c.action = ACT_TICK;
        else if (pick < 96)
            c.action = ACT_CANCEL;
        else
            c.action = ACT_UNUSED;
        c.task_key = ($urandom_range(9) < 8) ? 16'($urandom_range(15)) : 16'($urandom);
        lim = (cur_ndev < DEVICES) ? cur_ndev : DEVICES;
        if ($urandom_range(9) < 8 && lim > 0)
            c.need_devices = 5'($urandom_range(lim, 1));
        else
            c.need_devices = 5'($urandom_range(31));
        case ($urandom_range(4))
            0: c.need_memory = '0;
            1: c.need_memory = cur_cap;
            2: c.need_memory = 16'($urandom_range(cur_cap >> 2));
            3: c.need_memory = 16'($urandom_range(cur_cap >> 1));
            default: c.need_memory = 16'($urandom);
        endcase
        case ($urandom_range(9))
            0, 1, 2, 3, 4, 5, 6: c.duration = 16'($urandom_range(12));
            7, 8: c.duration = 16'($urandom_range(100));
            default: c.duration = 16'($urandom);
        endcase
        return c;
    endfunction

    // Offers one command; entered and left at a falling edge. The valid line
    // gets a single assignment per step, so a command that follows directly
    // keeps valid high without a glitch.
    task automatic offer_cmd(input in_t cmd, input logic typed, input out_t want);
        out_t model;
        while ($urandom_range(99) < send_gap_pct) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= cmd;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        // The predictor always runs so that its state follows the block.
        model = alloc_verdict(cmd);
        verdict_q.push_back(typed ? want : model);
        @(negedge aclk);
    endtask

    // Stops offering and waits for every owed outcome; the block is then idle.
    task automatic settle();
        s_valid <= 1'b0;
        @(negedge aclk);
        while (verdict_q.size() != 0) @(negedge aclk);
    endtask

    // Leaves cfg_valid high so that writes can follow back to back; the
    // caller lowers it once the sequence is done.
    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        apply_reg(idx, val);
        @(negedge aclk);
    endtask

    // ------------------------------------------------------------------
    // Result receiver: random back-pressure, plus one long hold-off counted
    // here whenever the stimulus asks for it.
    // ------------------------------------------------------------------
    initial begin
        m_ready = 1'b0;
        forever begin
            @(negedge aclk);
            if (hold_asks != hold_served) begin
                hold_served = hold_asks;
                hold_left   = HOLD_CYCLES;
            end
            if (hold_left != 0) begin
                hold_left--;
                m_ready <= 1'b0;
            end else begin
                m_ready <= ($urandom_range(99) >= recv_gap_pct);
            end
        end
    end

    // Result checker: each transfer is matched against the oldest outcome.
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (verdict_q.size() == 0) begin
                $error("result transfer with no command outstanding");
                mismatch_count++;
            end else begin
                seen_want = verdict_q.pop_front();
                if (m_data.accepted !== seen_want.accepted) begin
                    $error("accepted: expected %0b, actual %0b",
                           seen_want.accepted, m_data.accepted);
                    mismatch_count++;
                end
                if (m_data.table_full !== seen_want.table_full) begin
                    $error("table_full: expected %0b, actual %0b",
                           seen_want.table_full, m_data.table_full);
                    mismatch_count++;
                end
            end
        end
    end

    // Watchdog: a long run of cycles without any transfer means a hang.
    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready) ||
            (cfg_valid && cfg_ready)) begin
            quiet <= 0;
        end else if (quiet == STALL_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end else begin
            quiet <= quiet + 1;
        end
    end

    // ------------------------------------------------------------------
    // Main sequence.
    // ------------------------------------------------------------------
    row_t directed_rows [$];

    initial begin
        aresetn   = 1'b0;
        s_valid   = 1'b0;
        s_data    = '0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data  = '0;

        cur_ndev = RST_NUM_DEVICES;
        cur_cap  = RST_DEVICE_MEMORY;
        restart_alloc();

        // Directed commands under the reset setting of 16 devices with 16384
        // words each. Outcomes are typed in where they are plain to see.
        directed_rows.push_back(mk_row(ACT_TICK,   16'h0000,  5'd0, 16'h0000, 16'h0000, 1, 0, 0));
        directed_rows.push_back(mk_row(ACT_UNUSED, 16'hFFFF, 5'd31, 16'hFFFF, 16'hFFFF, 1, 0, 0));
        directed_rows.push_back(mk_row(ACT_CANCEL, 16'hFFFF,  5'd0, 16'h0000, 16'h0000, 1, 0, 0));
        // Whole capacity of every device, with a zero duration.
        directed_rows.push_back(mk_row(ACT_SUBMIT, 16'h0000, 5'd16, 16'd16384, 16'h0000, 1, 1, 0));
        directed_rows.push_back(mk_row(ACT_SUBMIT, 16'h0001,  5'd1, 16'h0000, 16'd3,    0, 0, 0));
        // Zero devices asked, once with device 0 short of room and once not.
        directed_rows.push_back(mk_row(ACT_SUBMIT, 16'h0002,  5'd0, 16'h0001, 16'd5,    0, 0, 0));
        directed_rows.push_back(mk_row(ACT_SUBMIT, 16'h0003,  5'd0, 16'h0000, 16'd5,    0, 0, 0));
        // More devices asked than exist, and more memory than any device has.
        directed_rows.push_back(mk_row(ACT_SUBMIT, 16'h0004, 5'd31, 16'h0000, 16'd1,    1, 0, 0));
        directed_rows.push_back(mk_row(ACT_SUBMIT, 16'h0005,  5'd1, 16'hFFFF, 16'd1,    1, 0, 0));
        // Cancelling the zero-duration task, then cancelling it again.
        directed_rows.push_back(mk_row(ACT_CANCEL, 16'h0000,  5'd0, 16'h0000, 16'h0000, 1, 1, 0));
        directed_rows.push_back(mk_row(ACT_CANCEL, 16'h0000,  5'd0, 16'h0000, 16'h0000, 1, 0, 0));
        // Three ticks reach the end time of key 1; cancelling it then fails.
        directed_rows.push_back(mk_row(ACT_TICK,   16'h0000,  5'd0, 16'h0000, 16'h0000, 0, 0, 0));
        directed_rows.push_back(mk_row(ACT_TICK,   16'h0000,  5'd0, 16'h0000, 16'h0000, 0, 0, 0));
        directed_rows.push_back(mk_row(ACT_TICK,   16'h0000,  5'd0, 16'h0000, 16'h0000, 0, 0, 0));
        directed_rows.push_back(mk_row(ACT_CANCEL, 16'h0001,  5'd0, 16'h0000, 16'h0000, 0, 0, 0));
        directed_rows.push_back(mk_row(ACT_SUBMIT, 16'hAAAA, 5'd16, 16'hFFFF, 16'hFFFF, 1, 0, 0));
        directed_rows.push_back(mk_row(ACT_SUBMIT, 16'h5555,  5'd8, 16'd8192, 16'd2,    0, 0, 0));
        directed_rows.push_back(mk_row(ACT_CANCEL, 16'h5555,  5'd0, 16'h0000, 16'h0000, 0, 0, 0));

        repeat (7) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;
        @(negedge aclk);

        send_gap_pct = 9;
        recv_gap_pct = 53;
        foreach (directed_rows[k])
            offer_cmd(directed_rows[k].cmd, directed_rows[k].typed, directed_rows[k].want);

        // Random phases, each under its own register setting. The first four
        // idle mostly on the result side, the next three on the command side,
        // and the last three run without idling.
        for (int ph = 0; ph < PHASES; ph++) begin
            if (ph < 4) begin
                send_gap_pct = 9;
                recv_gap_pct = 53;
            end else if (ph < 7) begin
                send_gap_pct = 53;
                recv_gap_pct = 9;
            end else begin
                send_gap_pct = 0;
                recv_gap_pct = 0;
            end

            // Registers change only once every outcome has been delivered.
            settle();
            case (ph)
                0: begin
                    write_reg(CFG_NUM_DEVICES, 16'd1);
                    write_reg(CFG_DEVICE_MEMORY, 16'hFFFF);
                end
                1: begin
                    write_reg(CFG_NUM_DEVICES, 16'd16);
                    write_reg(CFG_DEVICE_MEMORY, 16'h0000);
                end
                2: begin
                    write_reg(CFG_NUM_DEVICES, 16'd0);
                    write_reg(CFG_DEVICE_MEMORY, 16'd500);
                end
                3: begin
                    // Upper data bits are dropped, leaving a count beyond
                    // the number of devices present.
                    write_reg(CFG_NUM_DEVICES, 16'hFFFF);
                    write_reg(CFG_DEVICE_MEMORY, 16'd16384);
                end
                4: begin
                    write_reg(CFG_NUM_DEVICES, 16'd16);
                    write_reg(CFG_DEVICE_MEMORY, 16'hFFFF);
                end
                5: begin
                    write_reg(CFG_NUM_DEVICES, 16'd5);
                    write_reg(CFG_DEVICE_MEMORY, 16'd1000);
                    // A write to an unmapped index must leave everything alone.
                    write_reg(CFG_UNUSED, 16'($urandom));
                end
                6: write_reg(CFG_DEVICE_MEMORY, 16'd12000);
                7: begin
                    write_reg(CFG_NUM_DEVICES, 16'($urandom_range(16, 1)));
                    write_reg(CFG_DEVICE_MEMORY, 16'($urandom));
                end
                8: begin
                    write_reg(CFG_NUM_DEVICES, 16'd2);
                    write_reg(CFG_DEVICE_MEMORY, 16'd40000);
                end
                default: begin
                    write_reg(CFG_NUM_DEVICES, 16'($urandom_range(31)));
                    write_reg(CFG_DEVICE_MEMORY, 16'($urandom));
                end
            endcase
            cfg_valid <= 1'b0;

            for (int i = 0; i < PHASE_CMDS; i++) begin
                // Partway through the first phase the receiver holds off for
                // a long stretch while commands keep coming, so the block
                // fills up and stalls its input.
                if (ph == 0 && i == 30) hold_asks++;
                // With zero capacity most submits are free, so a submit-heavy
                // mix runs the task table full.
                offer_cmd(gen_cmd(ph == 1 ? 80 : 45), 1'b0, '0);
            end
        end

        settle();
        repeat (DRAIN_WAIT) @(posedge aclk);

        if (verdict_q.size() != 0) begin
            $error("%0d outcomes never delivered", verdict_q.size());
            mismatch_count++;
        end
        if (mismatch_count == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule

`default_nettype wire
